[rtl/core/epfm_pkg.sv]
// Package for the edge period frequency meter: widths, reset values,
// the measurement record passed from front to back, and the divider states.
// No dependencies.
package epfm_pkg;

  localparam int unsigned ClkHzW        = 28;
  localparam int unsigned PeriodW       = 32;
  localparam int unsigned CountWidthDef = 32;
  localparam int unsigned QueueDepthDef = 4;

  localparam logic [ClkHzW-1:0] ClockHzReset = ClkHzW'(48000000);

  // One finished measurement waiting for its reciprocal.
  typedef struct packed {
    logic [PeriodW-1:0] period;
    logic               ovf;
  } meas_t;

  typedef enum logic [1:0] {
    DivIdle,
    DivRun,
    DivWait
  } div_state_e;

endpackage

[rtl/core/epfm_if.sv]
// Handshake channels of the edge period frequency meter: ticks in,
// results out, and the clock rate register write. Depends on epfm_pkg.
interface epfm_tick_if;
  logic valid;
  logic ready;
  logic signal_level;

  modport source (output valid, output signal_level, input ready);
  modport sink   (input valid, input signal_level, output ready);
endinterface

interface epfm_result_if;
  import epfm_pkg::*;
  logic               valid;
  logic               ready;
  logic [ClkHzW-1:0]  frequency;
  logic [PeriodW-1:0] period_ticks;
  logic               count_overflow;

  modport source (output valid, output frequency, output period_ticks,
                  output count_overflow, input ready);
  modport sink   (input valid, input frequency, input period_ticks,
                  input count_overflow, output ready);
endinterface

interface epfm_cfg_if;
  import epfm_pkg::*;
  logic              valid;
  logic              ready;
  logic [ClkHzW-1:0] clock_hz;

  modport source (output valid, output clock_hz, input ready);
  modport sink   (input valid, input clock_hz, output ready);
endinterface

[rtl/core/epfm_front.sv]
// Front end: rising edge detection, start/stop alternation and the
// saturating tick counter. Depends on epfm_pkg and epfm_if.
module epfm_front #(
  parameter int unsigned COUNT_WIDTH = epfm_pkg::CountWidthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  epfm_tick_if.sink       tick,
  input  logic            q_full_i,
  output logic            push_o,
  output epfm_pkg::meas_t meas_o
);
  import epfm_pkg::*;

  localparam int unsigned CntW = (COUNT_WIDTH < PeriodW) ? COUNT_WIDTH : PeriodW;

  logic            prev_q, prev_d;
  logic            armed_q, armed_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            sat_q, sat_d;
  logic            accept, rise, at_limit;
  logic [CntW-1:0] cnt_inc;
  logic            sat_inc;

  // Ticks are held off whenever the queue is full, so a stop edge never finds it full.
  assign tick.ready = !q_full_i;
  assign accept     = tick.valid && tick.ready;
  assign rise       = tick.signal_level && !prev_q;
  assign at_limit   = &cnt_q;
  assign cnt_inc    = at_limit ? cnt_q : cnt_q + CntW'(1);
  assign sat_inc    = sat_q || at_limit;

  always_comb begin
    prev_d  = prev_q;
    armed_d = armed_q;
    cnt_d   = cnt_q;
    sat_d   = sat_q;
    push_o  = 1'b0;
    if (accept) begin
      prev_d = tick.signal_level;
      if (armed_q) begin
        cnt_d = cnt_inc;
        sat_d = sat_inc;
        if (rise) begin
          armed_d = 1'b0;
          push_o  = 1'b1;
        end
      end else if (rise) begin
        cnt_d   = '0;
        sat_d   = 1'b0;
        armed_d = 1'b1;
      end
    end
  end

  assign meas_o.period = PeriodW'(cnt_inc);
  assign meas_o.ovf    = sat_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b0;
      armed_q <= 1'b0;
      cnt_q   <= '0;
      sat_q   <= 1'b0;
    end else begin
      prev_q  <= prev_d;
      armed_q <= armed_d;
      cnt_q   <= cnt_d;
      sat_q   <= sat_d;
    end
  end

  // The saturated flag can only be raised once the counter sits at its limit.
  a_sat_at_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> at_limit)
    else $error("saturated flag set below the counter limit");

endmodule

[rtl/core/epfm_fifo.sv]
// Short queue of finished measurements between the front end and the
// divider. Depends on epfm_pkg.
module epfm_fifo #(
  parameter int unsigned Depth = epfm_pkg::QueueDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  epfm_pkg::meas_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            nonempty_o,
  output epfm_pkg::meas_t rdata_o
);
  import epfm_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  meas_t           mem [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] fill_q, fill_d;

  assign full_o     = (fill_q == CntW'(Depth));
  assign nonempty_o = (fill_q != '0);
  assign rdata_o    = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("measurement pushed into a full queue");

  a_no_underrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> nonempty_o)
    else $error("measurement popped from an empty queue");

endmodule

[rtl/core/epfm_div.sv]
// Back end: holds the clock rate register, divides it by each queued
// period one quotient bit per cycle, and drives the result register.
// Depends on epfm_pkg and epfm_if.
module epfm_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  epfm_cfg_if.sink        cfg,
  input  logic            meas_valid_i,
  input  epfm_pkg::meas_t meas_i,
  output logic            meas_pop_o,
  epfm_result_if.source   result
);
  import epfm_pkg::*;

  localparam int unsigned StepW = $clog2(ClkHzW);
  localparam logic [StepW-1:0] LastStep = StepW'(ClkHzW - 1);

  div_state_e         state_q, state_d;
  logic [ClkHzW-1:0]  clock_hz_q;
  logic [ClkHzW-1:0]  quo_q;      // dividend shifts out as quotient shifts in
  logic [ClkHzW-1:0]  rem_q;
  logic [PeriodW-1:0] dvs_q;
  logic               ovf_q;
  logic [StepW-1:0]   step_q;
  logic               out_valid_q, out_valid_d;
  logic [ClkHzW-1:0]  freq_q;
  logic [PeriodW-1:0] period_q;
  logic               out_ovf_q;

  logic               slot_free, start, run, load;
  logic [ClkHzW-1:0]  trial;
  logic               fits;

  assign cfg.ready = 1'b1;
  assign slot_free = !out_valid_q || result.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DivIdle: if (meas_valid_i) state_d = DivRun;
      DivRun:  if (step_q == '0) state_d = DivWait;
      DivWait: if (slot_free) state_d = DivIdle;
      default: state_d = DivIdle;
    endcase
  end

  always_comb begin
    start = 1'b0;
    run   = 1'b0;
    load  = 1'b0;
    unique case (state_q)
      DivIdle: start = meas_valid_i;
      DivRun:  run = 1'b1;
      DivWait: load = slot_free;
      default: ;
    endcase
  end

  assign meas_pop_o = start;

  // The partial remainder never exceeds the dividend, so 28 bits hold it.
  assign trial = {rem_q[ClkHzW-2:0], quo_q[ClkHzW-1]};
  assign fits  = PeriodW'(trial) >= dvs_q;

  assign out_valid_d = load ? 1'b1 : (result.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i) begin
    if (start) begin
      quo_q  <= clock_hz_q;
      rem_q  <= '0;
      dvs_q  <= meas_i.period;
      ovf_q  <= meas_i.ovf;
      step_q <= LastStep;
    end else if (run) begin
      rem_q  <= fits ? trial - ClkHzW'(dvs_q) : trial;
      quo_q  <= {quo_q[ClkHzW-2:0], fits};
      step_q <= step_q - StepW'(1);
    end
    if (load) begin
      freq_q    <= quo_q;
      period_q  <= dvs_q;
      out_ovf_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= DivIdle;
      out_valid_q <= 1'b0;
      clock_hz_q  <= ClockHzReset;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg.valid) begin
        clock_hz_q <= cfg.clock_hz;
      end
    end
  end

  assign result.valid          = out_valid_q;
  assign result.frequency      = freq_q;
  assign result.period_ticks   = period_q;
  assign result.count_overflow = out_ovf_q;

  // A stop edge always comes at least one tick after its start edge.
  a_divisor_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    run |-> (dvs_q != '0))
    else $error("divider running with a zero period");

  a_wait_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == DivWait && !slot_free) |=> (state_q == DivWait))
    else $error("quotient left the divider before the result register was free");

endmodule

[rtl/core/edge_period_frequency_meter.sv]
// Top level of the edge period frequency meter: front end, measurement
// queue and divider back end. Depends on epfm_pkg, epfm_if and the epfm modules.
// One tick item is accepted per cycle while the measurement queue has room.
// A result passes from its stop tick through the queue and the 28-step restoring
// divider into the result register; the divider takes one measurement at a time,
// and the queue absorbs up to QUEUE_DEPTH measurements. Reset clears the edge
// state, the counter, the queue and the result register, and sets clock_hz to 48 MHz.
module edge_period_frequency_meter #(
  parameter int unsigned COUNT_WIDTH = epfm_pkg::CountWidthDef,
  parameter int unsigned QUEUE_DEPTH = epfm_pkg::QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  epfm_tick_if.sink     tick_i,
  epfm_cfg_if.sink      cfg_i,
  epfm_result_if.source result_o
);
  import epfm_pkg::*;

  meas_t push_meas, pop_meas;
  logic  push, q_full, q_nonempty, pop;

  epfm_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick     (tick_i),
    .q_full_i (q_full),
    .push_o   (push),
    .meas_o   (push_meas)
  );

  epfm_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .wdata_i    (push_meas),
    .full_o     (q_full),
    .pop_i      (pop),
    .nonempty_o (q_nonempty),
    .rdata_o    (pop_meas)
  );

  epfm_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg          (cfg_i),
    .meas_valid_i (q_nonempty),
    .meas_i       (pop_meas),
    .meas_pop_o   (pop),
    .result       (result_o)
  );

endmodule
